// ----- design/keyboard_line_editor_macros.svh -----
// Assertion macros used by the checker file of the line editor.
`ifndef KEYBOARD_LINE_EDITOR_MACROS_SVH
`define KEYBOARD_LINE_EDITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyboard_line_editor check failed");

// The consequent must hold in the cycle after the antecedent.
`define KLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyboard_line_editor check failed");

`endif

// ----- design/kle_pkg.sv -----
package kle_pkg;

  // Line store geometry.
  localparam int LINE_DEPTH = 32;
  localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Scancode values (set 1).
  localparam logic [6:0] SC_CTRL  = 7'h1D;
  localparam logic [6:0] SC_SHIFT = 7'h2A;
  localparam logic [6:0] SC_ALT   = 7'h38;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  // Input item: a scancode byte or a keymap table write.
  typedef struct packed {
    logic       func;
    logic [7:0] code;
    logic [7:0] map_char;
  } key_t;

  // Result item.
  typedef struct packed {
    logic       channel;
    logic [7:0] out_byte;
    logic       last;
  } res_t;

  // How the looked-up character edits the line.
  typedef enum logic [1:0] {
    CLS_IGNORE,
    CLS_BS,
    CLS_LF,
    CLS_OTHER
  } char_class_t;

  // Source of an emitted byte.
  typedef enum logic [2:0] {
    SEL_CHAR,
    SEL_BS,
    SEL_SPACE,
    SEL_DOLLAR,
    SEL_LINE
  } byte_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      exec;
    logic      push;
    logic      pop;
    logic      rd_clear;
    logic      rd_adv;
    logic      line_clear;
    logic      emit;
    byte_sel_t sel;
    logic      last;
  } kle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic        is_write;
    logic        is_release;
    char_class_t cls;
    logic        empty;
    logic        full;
    logic        rd_last;
    logic        out_free;
  } kle_stat_t;

endpackage

// ----- design/kle_ctrl.sv -----
module kle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  output logic              busy,
  input  kle_pkg::kle_stat_t stat,
  output kle_pkg::kle_cmd_t  cmd
);
  import kle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CLASS,
    S_ECHO,
    S_BS1,
    S_BS2,
    S_BS3,
    S_LF_ECHO,
    S_LINE,
    S_PROMPT1,
    S_PROMPT2
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SEL_CHAR;
    unique case (state)
      S_IDLE: begin
        if (key_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_write || stat.is_release) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        unique case (stat.cls)
          CLS_IGNORE: state_next = S_IDLE;
          CLS_BS: begin
            if (stat.empty) begin
              state_next = S_IDLE;
            end else begin
              cmd.pop    = 1'b1;
              state_next = S_BS1;
            end
          end
          CLS_LF: begin
            cmd.push     = 1'b1;
            cmd.rd_clear = 1'b1;
            state_next   = S_LF_ECHO;
          end
          CLS_OTHER: begin
            if (stat.full) begin
              state_next = S_IDLE;
            end else begin
              cmd.push   = 1'b1;
              state_next = S_ECHO;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_ECHO: begin
        cmd.sel  = SEL_CHAR;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BS1: begin
        cmd.sel = SEL_BS;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_BS2;
        end
      end
      S_BS2: begin
        cmd.sel = SEL_SPACE;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_BS3;
        end
      end
      S_BS3: begin
        cmd.sel  = SEL_BS;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LF_ECHO: begin
        cmd.sel = SEL_CHAR;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_LINE;
        end
      end
      S_LINE: begin
        // The line is never empty here: it holds the newline, or it is full.
        cmd.sel = SEL_LINE;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.rd_adv = 1'b1;
          if (stat.rd_last) begin
            cmd.line_clear = 1'b1;
            state_next     = S_PROMPT1;
          end
        end
      end
      S_PROMPT1: begin
        cmd.sel = SEL_DOLLAR;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_PROMPT2;
        end
      end
      S_PROMPT2: begin
        cmd.sel  = SEL_SPACE;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/kle_datapath.sv -----
module kle_datapath (
  input  logic               clk,
  input  logic               rst,
  input  kle_pkg::key_t      key_data,
  output logic               res_valid,
  input  logic               res_stall,
  output kle_pkg::res_t      res_data,
  input  kle_pkg::kle_cmd_t  cmd,
  output kle_pkg::kle_stat_t stat
);
  import kle_pkg::*;

  key_t             item;
  logic             ctrl_held;
  logic             shift_held;
  logic             alt_held;
  logic [7:0]       km_mem [256];
  logic [255:0]     km_valid;
  logic [7:0]       km_q;
  logic             km_hit;
  logic [7:0]       ch;
  char_class_t      cls;
  logic [7:0]       ls_mem [LINE_DEPTH];
  logic [7:0]       ls_q;
  logic [LEN_W-1:0] line_length;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] rd_idx_next;
  logic             ctrl_upd;
  logic             shift_upd;
  logic             alt_upd;
  logic [7:0]       km_idx;
  logic             is_press;
  logic             full;
  logic [7:0]       emit_byte;

  // Item register, loaded when the transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= key_data;
    end
  end

  assign is_press = !item.func && !item.code[7];

  // Modifier values as they stand after this item.
  always_comb begin
    ctrl_upd  = ctrl_held;
    shift_upd = shift_held;
    alt_upd   = alt_held;
    if (!item.func) begin
      if (item.code[6:0] == SC_CTRL)  ctrl_upd  = !item.code[7];
      if (item.code[6:0] == SC_SHIFT) shift_upd = !item.code[7];
      if (item.code[6:0] == SC_ALT)   alt_upd   = !item.code[7];
    end
  end

  // Keymap index: scancode, or zero under ctrl or alt, plus 128 under shift.
  assign km_idx = {shift_upd, (ctrl_upd || alt_upd) ? 7'd0 : item.code[6:0]};

  // Modifier flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_held  <= 1'b0;
      shift_held <= 1'b0;
      alt_held   <= 1'b0;
    end else if (cmd.exec) begin
      ctrl_held  <= ctrl_upd;
      shift_held <= shift_upd;
      alt_held   <= alt_upd;
    end
  end

  // Keymap valid bits; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      km_valid <= '0;
    end else if (cmd.exec && item.func) begin
      km_valid[item.code] <= 1'b1;
    end
  end

  // Keymap memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && item.func) begin
      km_mem[item.code] <= item.map_char;
    end
    if (cmd.exec && is_press) begin
      km_q   <= km_mem[km_idx];
      km_hit <= km_valid[km_idx];
    end
  end

  assign ch = km_hit ? km_q : CH_NUL;

  // Classify the looked-up character.
  always_comb begin
    unique case (ch)
      CH_NUL, CH_CR, CH_TAB: cls = CLS_IGNORE;
      CH_BS:                 cls = CLS_BS;
      CH_LF:                 cls = CLS_LF;
      default:               cls = CLS_OTHER;
    endcase
  end

  assign full = (line_length == LEN_W'(LINE_DEPTH));

  // Line length.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
    end else if (cmd.line_clear) begin
      line_length <= '0;
    end else if (cmd.push && !full) begin
      line_length <= line_length + LEN_W'(1);
    end else if (cmd.pop) begin
      line_length <= line_length - LEN_W'(1);
    end
  end

  // Read pointer for draining the line.
  always_comb begin
    rd_idx_next = rd_idx;
    if (cmd.rd_clear) begin
      rd_idx_next = '0;
    end else if (cmd.rd_adv) begin
      rd_idx_next = rd_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else begin
      rd_idx <= rd_idx_next;
    end
  end

  // Line store: written at the line end, read every cycle ahead of the pointer.
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      ls_mem[line_length[IDX_W-1:0]] <= ch;
    end
    ls_q <= ls_mem[rd_idx_next];
  end

  // Byte selection for the output register.
  always_comb begin
    unique case (cmd.sel)
      SEL_CHAR:   emit_byte = ch;
      SEL_BS:     emit_byte = CH_BS;
      SEL_SPACE:  emit_byte = CH_SPACE;
      SEL_DOLLAR: emit_byte = CH_DOLLAR;
      SEL_LINE:   emit_byte = ls_q;
      default:    emit_byte = CH_NUL;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_data.channel  <= (cmd.sel == SEL_LINE);
      res_data.out_byte <= emit_byte;
      res_data.last     <= cmd.last;
    end
  end

  // Status.
  assign stat.is_write   = item.func;
  assign stat.is_release = item.code[7];
  assign stat.cls        = cls;
  assign stat.empty      = (line_length == '0);
  assign stat.full       = full;
  assign stat.rd_last    = ((LEN_W'(rd_idx) + LEN_W'(1)) == line_length);
  assign stat.out_free   = !res_valid || !res_stall;

endmodule

// ----- design/keyboard_line_editor.sv -----
// Channel  Signals                          Transaction
// key      key_valid, key_stall, key_data   scancode byte or keymap table write
// res      res_valid, res_stall, res_data   echo byte or completed line byte
//
// One item is in work at a time; key_stall is high from acceptance to the last result.
// A table write or key release passes through S_EXEC only; an ignored press also through S_CLASS.
// A press that produces output then emits its results one at a time, each waiting while res is stalled.
// The keymap and line store are single-read-port memories; the line drains one byte a cycle while res is not stalled.
// Reset clears the modifiers, the line length and the keymap valid bits.
// A stall on res holds the output register and pauses the controller.
module keyboard_line_editor (
  input  logic          clk,
  input  logic          rst,
  input  logic          key_valid,
  output logic          key_stall,
  input  kle_pkg::key_t key_data,
  output logic          res_valid,
  input  logic          res_stall,
  output kle_pkg::res_t res_data
);
  import kle_pkg::*;

  kle_cmd_t  cmd;
  kle_stat_t stat;
  logic      busy;

  assign key_stall = busy;

  kle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .busy      (busy),
    .stat      (stat),
    .cmd       (cmd)
  );

  kle_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .key_data  (key_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- design/kle_checker.sv -----
`include "keyboard_line_editor_macros.svh"

module kle_checker (
  input logic          clk,
  input logic          rst,
  input logic          key_valid,
  input logic          key_stall,
  input kle_pkg::key_t key_data,
  input logic          res_valid,
  input logic          res_stall,
  input kle_pkg::res_t res_data
);
  import kle_pkg::*;

  // A stalled result stays put.
  `KLE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data))

  // An accepted transaction keeps the input side closed in the next cycle.
  `KLE_ASSERT_NEXT(a_busy_after_accept, key_valid && !key_stall, key_stall)

  // A new result only appears while an item is in work.
  `KLE_ASSERT_SAME(a_result_in_work, $rose(res_valid), $past(key_stall))

  // Once the block is open again, a pending result is the final one of its item.
  `KLE_ASSERT_SAME(a_idle_last, !key_stall && res_valid, res_data.last)

endmodule

bind keyboard_line_editor kle_checker u_kle_checker (.*);

// ----- verif/keyboard_line_editor_tb.sv -----
`timescale 1ns / 1ps

module keyboard_line_editor_tb;
  import kle_pkg::*;

  // Result channels.
  localparam logic TO_DISPLAY = 1'b0;
  localparam logic TO_SHELL   = 1'b1;

  // Scancodes used for typing, besides the modifiers from the package.
  localparam logic [6:0] SC_NONE    = 7'h00;
  localparam logic [6:0] SC_ESC     = 7'h01;
  localparam logic [6:0] SC_BKSP    = 7'h0E;
  localparam logic [6:0] SC_TABKEY  = 7'h0F;
  localparam logic [6:0] SC_ROW_LO  = 7'h10;
  localparam logic [6:0] SC_ENTER   = 7'h1C;
  localparam logic [6:0] SC_SPACEBAR = 7'h39;
  localparam logic [6:0] SC_TOP     = 7'h7F;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic key_valid = 1'b0;
  logic key_stall;
  key_t key_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  // Predictor state: modifiers, keymap and the line being typed.
  logic ctrl_down;
  logic shift_down;
  logic alt_down;
  logic [7:0] keymap_copy [256];
  logic [7:0] typed_line [LINE_DEPTH];
  int line_len;

  // Bytes the editor still owes on its result port, oldest first.
  res_t owed_bytes [$];
  res_t want;
  int errors = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;

  keyboard_line_editor dut (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_data  (key_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The result side stalls at random, except during the quiet stretch.
  always @(posedge clk) begin
    res_stall <= !quiet && ($urandom_range(0, 99) < 7);
  end

  // Compare each result transaction with the oldest owed byte.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (owed_bytes.size() == 0) begin
        $display("%0t: expected no transaction, actual channel=%0d byte=%02h last=%0b",
                 $time, res_data.channel, res_data.out_byte, res_data.last);
        errors++;
      end else begin
        want = owed_bytes.pop_front();
        if (res_data.channel !== want.channel || res_data.out_byte !== want.out_byte ||
            res_data.last !== want.last) begin
          $display("%0t: expected channel=%0d byte=%02h last=%0b, %s=%0d byte=%02h last=%0b",
                   $time, want.channel, want.out_byte, want.last, "actual channel",
                   res_data.channel, res_data.out_byte, res_data.last);
          errors++;
        end
      end
    end
  end

  function automatic void owe(logic ch, logic [7:0] b, logic fin);
    res_t r;
    r.channel = ch;
    r.out_byte = b;
    r.last = fin;
    owed_bytes.push_back(r);
  endfunction

  // Work out the bytes that one accepted transaction produces.
  function automatic void apply_keystroke(key_t k);
    logic [6:0] sc;
    logic [7:0] idx;
    logic [7:0] c;
    sc = k.code[6:0];
    if (k.func) begin
      keymap_copy[k.code] = k.map_char;
    end else if (k.code[7]) begin
      // A release only clears a modifier.
      if (sc == SC_CTRL) ctrl_down = 1'b0;
      if (sc == SC_SHIFT) shift_down = 1'b0;
      if (sc == SC_ALT) alt_down = 1'b0;
    end else begin
      if (sc == SC_CTRL) ctrl_down = 1'b1;
      if (sc == SC_SHIFT) shift_down = 1'b1;
      if (sc == SC_ALT) alt_down = 1'b1;
      idx = (ctrl_down || alt_down) ? 8'h00 : {1'b0, sc};
      if (shift_down) idx[7] = 1'b1;
      c = keymap_copy[idx];
      case (c)
        CH_NUL, CH_CR, CH_TAB: ;
        CH_BS: begin
          if (line_len > 0) begin
            line_len--;
            owe(TO_DISPLAY, CH_BS, 1'b0);
            owe(TO_DISPLAY, CH_SPACE, 1'b0);
            owe(TO_DISPLAY, CH_BS, 1'b1);
          end
        end
        CH_LF: begin
          // A full line keeps its bytes and loses the newline.
          if (line_len < LINE_DEPTH) begin
            typed_line[line_len] = c;
            line_len++;
          end
          owe(TO_DISPLAY, CH_LF, 1'b0);
          for (int i = 0; i < line_len; i++) owe(TO_SHELL, typed_line[i], 1'b0);
          line_len = 0;
          owe(TO_DISPLAY, CH_DOLLAR, 1'b0);
          owe(TO_DISPLAY, CH_SPACE, 1'b1);
        end
        default: begin
          if (line_len < LINE_DEPTH) begin
            typed_line[line_len] = c;
            line_len++;
            owe(TO_DISPLAY, c, 1'b1);
          end
        end
      endcase
    end
  endfunction

  // Send one transaction on the key channel, with an occasional gap before it.
  task automatic send_key(key_t k);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      key_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    key_valid <= 1'b1;
    key_data <= k;
    @(posedge clk);
    while (key_stall) @(posedge clk);
    apply_keystroke(k);
  endtask

  task automatic press_key(logic [6:0] sc);
    send_key('{func: 1'b0, code: {1'b0, sc}, map_char: 8'($urandom_range(0, 255))});
  endtask

  task automatic lift_key(logic [6:0] sc);
    send_key('{func: 1'b0, code: {1'b1, sc}, map_char: 8'($urandom_range(0, 255))});
  endtask

  task automatic write_map(logic [7:0] slot, logic [7:0] ch);
    send_key('{func: 1'b1, code: slot, map_char: ch});
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // Mostly printable characters, with the editing characters mixed in.
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return printable();
    if (roll < 71) return CH_BS;
    if (roll < 77) return CH_LF;
    if (roll < 81) return CH_CR;
    if (roll < 85) return CH_TAB;
    if (roll < 88) return CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [6:0] letter_key();
    return SC_ROW_LO + 7'($urandom_range(0, 9));
  endfunction

  // With an empty keymap every press looks up NUL and produces nothing.
  task automatic test_unmapped_keys();
    press_key(SC_ROW_LO);
    press_key(SC_NONE);
    lift_key(SC_ROW_LO);
    lift_key(SC_NONE);
  endtask

  // Load a small layout, including the index used under ctrl or alt.
  task automatic test_keymap_load();
    write_map(8'h00, printable());
    write_map(8'h80, printable());
    write_map(8'hFF, 8'hFF);
    write_map({1'b1, SC_SHIFT}, printable());
    for (int i = 0; i < 10; i++) begin
      write_map({1'b0, SC_ROW_LO + 7'(i)}, printable());
      write_map({1'b1, SC_ROW_LO + 7'(i)}, printable());
    end
    write_map({1'b0, SC_BKSP}, CH_BS);
    write_map({1'b1, SC_BKSP}, CH_BS);
    write_map({1'b0, SC_ENTER}, CH_LF);
    write_map({1'b1, SC_ENTER}, CH_LF);
    write_map({1'b0, SC_TABKEY}, CH_TAB);
    write_map({1'b0, SC_ESC}, CH_CR);
    write_map({1'b0, SC_SPACEBAR}, CH_SPACE);
  endtask

  // Backspace, ignored characters, every modifier and newline.
  task automatic test_directed_edits();
    press_key(SC_BKSP);
    press_key(SC_ROW_LO);
    press_key(SC_ROW_LO + 7'd1);
    press_key(SC_BKSP);
    press_key(SC_ESC);
    press_key(SC_TABKEY);
    press_key(SC_SPACEBAR);
    // The shift key looks up its own shifted entry.
    press_key(SC_SHIFT);
    press_key(SC_ROW_LO + 7'd2);
    press_key(SC_TOP);
    lift_key(SC_SHIFT);
    press_key(SC_CTRL);
    press_key(SC_ROW_LO + 7'd3);
    press_key(SC_SHIFT);
    lift_key(SC_SHIFT);
    lift_key(SC_CTRL);
    press_key(SC_ALT);
    lift_key(SC_ALT);
    lift_key(SC_ROW_LO + 7'd3);
    press_key(SC_ENTER);
    // Newline on an empty line still sends the newline itself.
    press_key(SC_ENTER);
  endtask

  // Fill the line exactly, then overflow it and end it while full.
  task automatic test_full_line();
    repeat (LINE_DEPTH - 1) press_key(letter_key());
    press_key(SC_ENTER);
    repeat (LINE_DEPTH + 1) press_key(letter_key());
    press_key(SC_BKSP);
    press_key(letter_key());
    press_key(letter_key());
    press_key(SC_ENTER);
  endtask

  // Mostly typing on the mapped keys, with remaps, modifiers and noise.
  task automatic test_random_typing(int count);
    int roll;
    int pick;
    logic [6:0] sc;
    for (int n = 0; n < count; n++) begin
      quiet = (n >= 40 && n < 140);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        write_map(8'($urandom_range(0, 255)), pick_char());
      end else if (roll < 20) begin
        pick = $urandom_range(0, 4);
        sc = (pick == 0) ? SC_CTRL : (pick == 1) ? SC_SHIFT : (pick == 2) ? SC_ALT :
             7'($urandom_range(0, 127));
        lift_key(sc);
      end else if (roll < 26) begin
        pick = $urandom_range(0, 2);
        press_key((pick == 0) ? SC_CTRL : (pick == 1) ? SC_SHIFT : SC_ALT);
      end else if (roll < 34) begin
        press_key(7'($urandom_range(0, 127)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) press_key(letter_key());
        else if (pick < 88) press_key(SC_BKSP);
        else if (pick < 96) press_key(SC_ENTER);
        else if (pick < 98) press_key(SC_SPACEBAR);
        else press_key(SC_TABKEY);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    ctrl_down = 1'b0;
    shift_down = 1'b0;
    alt_down = 1'b0;
    line_len = 0;
    foreach (keymap_copy[i]) keymap_copy[i] = 8'h00;
    foreach (typed_line[i]) typed_line[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unmapped_keys();
    test_keymap_load();
    test_directed_edits();
    test_full_line();
    test_random_typing(185);

    key_valid <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
